### sv/kdhl_pkg.sv
// shared types and constants for the key debounce, hold and lock unit
package kdhl_pkg;

  localparam int unsigned OutKeys      = 3;
  localparam int unsigned NumKeysDef   = 3;
  localparam int unsigned HoldW        = 16;
  localparam int unsigned CntW         = 8;
  localparam logic [HoldW-1:0] HoldMax = {HoldW{1'b1}};
  localparam logic [CntW-1:0] ThreshRst = CntW'(1);

  // state of one key as seen by the merge stage after this tick's scan
  typedef struct packed {
    logic [HoldW-1:0] hold;
    logic             lock;
  } lane_status_t;

endpackage

### sv/kdhl_lane.sv
// one key lane: debounce counter, hold count and lock flag
module kdhl_lane import kdhl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             level_i,
  input  logic             lock_set_i,
  input  logic [CntW-1:0]  thresh_i,
  output lane_status_t     status_o
);

  logic [HoldW-1:0] hold_q, hold_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             lock_q, lock_d;

  always_comb begin
    hold_d = hold_q;
    cnt_d  = cnt_q;
    lock_d = lock_q | lock_set_i;
    if (hold_q != '0) begin
      if (level_i) begin
        if (hold_q != HoldMax) hold_d = hold_q + HoldW'(1);
        cnt_d = thresh_i;
      end else if (cnt_q == '0) begin
        // release clears the lock, even one set this tick
        hold_d = '0;
        lock_d = 1'b0;
      end else begin
        cnt_d = cnt_q - CntW'(1);
      end
    end else begin
      if (!level_i) begin
        cnt_d = thresh_i;
      end else if (cnt_q == '0) begin
        hold_d = HoldW'(1);
      end else begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
      cnt_q  <= '0;
      lock_q <= 1'b0;
    end else if (adv_i) begin
      hold_q <= hold_d;
      cnt_q  <= cnt_d;
      lock_q <= lock_d;
    end
  end

  assign status_o.hold = hold_d;
  assign status_o.lock = lock_d;

endmodule

### sv/kdhl_merge.sv
// merges the lane results into the registered output item
module kdhl_merge import kdhl_pkg::*; #(
  parameter int unsigned NUM_KEYS = NumKeysDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             out_stall_i,
  input  lane_status_t     lane_status_i [NUM_KEYS],
  output logic             out_valid_o,
  output logic [OutKeys-1:0] active_o,
  output logic [HoldW-1:0] hold_o [OutKeys]
);

  logic                 valid_q, valid_d;
  logic [OutKeys-1:0]   active_q, active_d;
  logic [HoldW-1:0]     hold_q [OutKeys];
  logic [HoldW-1:0]     hold_d [OutKeys];

  for (genvar i = 0; i < OutKeys; i++) begin : g_out
    if (i < NUM_KEYS) begin : g_key
      // locked keys read as released
      assign hold_d[i]   = lane_status_i[i].lock ? '0 : lane_status_i[i].hold;
      assign active_d[i] = !lane_status_i[i].lock && (lane_status_i[i].hold != '0);
    end else begin : g_none
      assign hold_d[i]   = '0;
      assign active_d[i] = 1'b0;
    end
  end

  assign valid_d = load_i | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      active_q <= active_d;
      hold_q   <= hold_d;
    end
  end

  assign out_valid_o = valid_q;
  assign active_o    = active_q;
  assign hold_o      = hold_q;

endmodule

### sv/key_debounce_hold_lock_unit.sv
// top level: key debounce, hold count and lock for a set of keys
// output: the result of an accepted tick is in the output register from the next cycle on
// throughput: one tick per cycle; a tick is taken while the output register is empty
//   or its result is taken in the same cycle
// reset: all keys released, counters and locks clear, debounce threshold 1
module key_debounce_hold_lock_unit import kdhl_pkg::*; #(
  parameter int unsigned NUM_KEYS = NumKeysDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OutKeys-1:0]  key_levels_i,
  input  logic [OutKeys-1:0]  lock_mask_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OutKeys-1:0]  active_keys_o,
  output logic [HoldW-1:0]    hold_up_o,
  output logic [HoldW-1:0]    hold_down_o,
  output logic [HoldW-1:0]    hold_power_o,
  input  logic                cfg_we_i,
  input  logic [CntW-1:0]     cfg_wdata_i
);

  logic [CntW-1:0] thresh_q;
  logic            accept;
  lane_status_t    lane_status [NUM_KEYS];
  logic [HoldW-1:0] hold [OutKeys];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshRst;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = out_valid_o & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic level, lock_set;
    if (k < OutKeys) begin : g_port
      assign level    = key_levels_i[k];
      assign lock_set = lock_mask_i[k];
    end else begin : g_extra
      // keys without a pin stay released and unlocked
      assign level    = 1'b0;
      assign lock_set = 1'b0;
    end
    kdhl_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (accept),
      .level_i    (level),
      .lock_set_i (lock_set),
      .thresh_i   (thresh_q),
      .status_o   (lane_status[k])
    );
  end

  kdhl_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .out_stall_i   (out_stall_i),
    .lane_status_i (lane_status),
    .out_valid_o   (out_valid_o),
    .active_o      (active_keys_o),
    .hold_o        (hold)
  );

  assign hold_up_o    = hold[0];
  assign hold_down_o  = hold[1];
  assign hold_power_o = hold[2];

endmodule

### sv/kdhl_checker.sv
// port-level checks for the key debounce, hold and lock unit
module kdhl_checker import kdhl_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [OutKeys-1:0]  active_keys_o,
  input logic [HoldW-1:0]    hold_up_o,
  input logic [HoldW-1:0]    hold_down_o,
  input logic [HoldW-1:0]    hold_power_o
);

  // an accepted tick always shows up as a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item produced no result");

  // input is held back only by a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  // a key is active exactly when its reported hold count is nonzero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (active_keys_o[0] == (hold_up_o != '0)) &&
                    (active_keys_o[1] == (hold_down_o != '0)) &&
                    (active_keys_o[2] == (hold_power_o != '0)))
    else $error("active mask disagrees with hold counts");

  // a stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

bind key_debounce_hold_lock_unit kdhl_checker u_kdhl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .active_keys_o (active_keys_o),
  .hold_up_o     (hold_up_o),
  .hold_down_o   (hold_down_o),
  .hold_power_o  (hold_power_o)
);

### dv/tb_key_debounce_hold_lock_unit.sv
// testbench for key_debounce_hold_lock_unit: scan ticks against a key state predictor
module tb_key_debounce_hold_lock_unit;
  import kdhl_pkg::*;

  localparam int unsigned CycleLimit = 1000000;

  typedef struct packed {
    logic [OutKeys-1:0] levels;
    logic [OutKeys-1:0] locks;
  } scan_tick_t;

  typedef struct packed {
    logic [OutKeys-1:0] active;
    logic [HoldW-1:0]   up;
    logic [HoldW-1:0]   down;
    logic [HoldW-1:0]   power;
  } key_report_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [OutKeys-1:0] key_levels_i = '0;
  logic [OutKeys-1:0] lock_mask_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [OutKeys-1:0] active_keys_o;
  logic [HoldW-1:0]   hold_up_o;
  logic [HoldW-1:0]   hold_down_o;
  logic [HoldW-1:0]   hold_power_o;
  logic               cfg_we_i = 1'b0;
  logic [CntW-1:0]    cfg_wdata_i = '0;

  key_debounce_hold_lock_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .key_levels_i (key_levels_i),
    .lock_mask_i  (lock_mask_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .active_keys_o(active_keys_o),
    .hold_up_o    (hold_up_o),
    .hold_down_o  (hold_down_o),
    .hold_power_o (hold_power_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  scan_tick_t  tick_q[$];
  key_report_t report_q[$];

  // predicted key state
  logic [HoldW-1:0]   hold_st[OutKeys] = '{default: '0};
  logic [CntW-1:0]    bounce_st[OutKeys] = '{default: '0};
  logic [OutKeys-1:0] lock_st = '0;
  logic [CntW-1:0]    thresh_st = ThreshRst;

  int unsigned idle_mode = 1;
  int unsigned in_gap = 0;
  int unsigned out_wait = 0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned report_cnt = 0;
  key_report_t got_rep;
  key_report_t want_rep;

  // 0: no idling, 1: a random idle gap before every item, 2: mostly back to back
  function automatic int unsigned draw_wait();
    if (idle_mode == 0) return 0;
    if (idle_mode == 2 && $urandom_range(0, 4) != 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic key_report_t advance_keys(logic [OutKeys-1:0] levels,
                                               logic [OutKeys-1:0] locks);
    key_report_t        rep;
    logic [HoldW-1:0]   shown[OutKeys];
    logic [OutKeys-1:0] act;
    lock_st = lock_st | locks;
    for (int k = 0; k < OutKeys; k++) begin
      if (hold_st[k] != '0) begin
        if (levels[k]) begin
          if (hold_st[k] != HoldMax) hold_st[k] = hold_st[k] + HoldW'(1);
          bounce_st[k] = thresh_st;
        end else if (bounce_st[k] == '0) begin
          hold_st[k] = '0;
          lock_st[k] = 1'b0;
        end else begin
          bounce_st[k] = bounce_st[k] - CntW'(1);
        end
      end else begin
        if (!levels[k]) begin
          bounce_st[k] = thresh_st;
        end else if (bounce_st[k] == '0) begin
          hold_st[k] = HoldW'(1);
        end else begin
          bounce_st[k] = bounce_st[k] - CntW'(1);
        end
      end
    end
    for (int k = 0; k < OutKeys; k++) begin
      shown[k] = lock_st[k] ? '0 : hold_st[k];
      act[k] = (shown[k] != '0);
    end
    rep.active = act;
    rep.up = shown[0];
    rep.down = shown[1];
    rep.power = shown[2];
    return rep;
  endfunction

  // tick driver
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (in_valid_i) report_q.push_back(advance_keys(key_levels_i, lock_mask_i));
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (tick_q.size() != 0) begin
        key_levels_i <= tick_q[0].levels;
        lock_mask_i <= tick_q[0].locks;
        void'(tick_q.pop_front());
        in_valid_i <= 1'b1;
        in_gap <= draw_wait();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // report monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got_rep = {active_keys_o, hold_up_o, hold_down_o, hold_power_o};
        if (report_q.size() == 0) begin
          if (err_cnt < 10) $display("report %0d arrived with none pending", report_cnt);
          err_cnt++;
        end else begin
          want_rep = report_q.pop_front();
          if (got_rep !== want_rep) begin
            if (err_cnt < 10)
              $display("report %0d: active %b/%b up %0d/%0d down %0d/%0d power %0d/%0d",
                       report_cnt, want_rep.active, got_rep.active, want_rep.up, got_rep.up,
                       want_rep.down, got_rep.down, want_rep.power, got_rep.power);
            err_cnt++;
          end
        end
        report_cnt++;
        out_wait = draw_wait();
        out_stall_i <= (out_wait != 0);
      end else if (out_wait != 0) begin
        out_wait = out_wait - 1;
        out_stall_i <= (out_wait != 0);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_tick(input logic [OutKeys-1:0] lv, input logic [OutKeys-1:0] lk,
                           input int reps);
    scan_tick_t t;
    t.levels = lv;
    t.locks = lk;
    repeat (reps) tick_q.push_back(t);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (tick_q.size() != 0 || in_valid_i || report_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [CntW-1:0] val);
    wait_idle();
    repeat (2) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= CntW'($urandom_range(0, 255));
    thresh_st = val;
  endtask

  // runs of steady levels sized around the threshold, with glitches, locks and noise
  task automatic fill_random(input int thr, input int budget);
    int n;
    int len;
    logic [OutKeys-1:0] lv;
    logic [OutKeys-1:0] lk;
    n = 0;
    while (n < budget) begin
      if ($urandom_range(0, 4) != 0) begin
        lv = OutKeys'($urandom_range(0, 7));
        len = $urandom_range(0, 1) ? $urandom_range(1, thr + 3) : thr + $urandom_range(1, 2);
        for (int j = 0; j < len; j++) begin
          lk = ($urandom_range(0, 15) == 0) ? OutKeys'($urandom_range(0, 7)) : '0;
          if ($urandom_range(0, 31) == 0) push_tick(lv ^ (3'b001 << $urandom_range(0, 2)), lk, 1);
          else push_tick(lv, lk, 1);
        end
      end else begin
        len = $urandom_range(1, 8);
        for (int j = 0; j < len; j++)
          push_tick(OutKeys'($urandom_range(0, 7)), OutKeys'($urandom_range(0, 7)), 1);
      end
      n += len;
    end
  endtask

  int thr_list[10] = '{1, 2, 255, 0, 3, 255, 5, 0, 128, 1};

  initial begin
    thr_list[8] = $urandom_range(0, 255);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset threshold: press, lock while pressed, release, lock on a released key
    push_tick(3'b000, 3'b000, 1);
    push_tick(3'b111, 3'b000, 3);
    push_tick(3'b111, 3'b111, 1);
    push_tick(3'b111, 3'b000, 2);
    push_tick(3'b000, 3'b000, 3);
    push_tick(3'b000, 3'b001, 1);
    push_tick(3'b001, 3'b000, 3);
    push_tick(3'b000, 3'b000, 3);
    push_tick(3'b001, 3'b000, 3);
    push_tick(3'b010, 3'b000, 1);
    push_tick(3'b101, 3'b010, 1);
    push_tick(3'b111, 3'b111, 1);
    push_tick(3'b000, 3'b000, 3);

    // zero threshold: once the count left from the old threshold runs out, every level change is taken at once
    write_threshold(8'd0);
    push_tick(3'b111, 3'b000, 1);
    push_tick(3'b000, 3'b000, 1);
    push_tick(3'b111, 3'b000, 1);
    push_tick(3'b000, 3'b101, 1);
    push_tick(3'b111, 3'b000, 1);
    push_tick(3'b000, 3'b000, 1);

    // long holds, back to back on both sides
    wait_idle();
    idle_mode = 0;
    push_tick(3'b111, 3'b000, 200);
    push_tick(3'b111, 3'b010, 2);
    push_tick(3'b000, 3'b000, 2);

    for (int ph = 0; ph < 10; ph++) begin
      write_threshold(CntW'(thr_list[ph]));
      idle_mode = ph % 3;
      fill_random(thr_list[ph], (thr_list[ph] > 100) ? 350 : 100);
    end

    wait_idle();
    repeat (5) @(posedge clk_i);
    if (report_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
